FILE: rtl/core/srt_pkg.sv
// Shared types, constants and decode functions for the status register transfer unit.
`default_nettype none

package srt_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BANK_DEPTH = 5;
  localparam int unsigned SLOT_W     = 3;

  localparam logic [WORD_W-1:0] FLAG_BITS    = 32'hF800_0000;
  localparam logic [WORD_W-1:0] CTRL_BITS    = 32'h0000_00DF;
  localparam logic [WORD_W-1:0] STATE_BIT    = 32'h0000_0020;
  localparam logic [WORD_W-1:0] UNALLOC_BITS = 32'h07FF_FF00;
  localparam logic [WORD_W-1:0] RESET_STATUS = 32'h0000_01D3;

  localparam logic [WORD_W-1:0] FIELD_C = 32'h0000_00FF;
  localparam logic [WORD_W-1:0] FIELD_X = 32'h0000_FF00;
  localparam logic [WORD_W-1:0] FIELD_S = 32'h00FF_0000;
  localparam logic [WORD_W-1:0] FIELD_F = 32'hFF00_0000;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;

  localparam logic [SLOT_W-1:0] SLOT_FIQ = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_IRQ = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_SVC = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_ABT = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_UND = 3'd4;

  localparam logic [3:0] REG_PC = 4'd15;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] idx;
  } srt_slot_t;

  // State update from one executed instruction
  typedef struct packed {
    logic              cur_we;
    logic [WORD_W-1:0] cur_val;
    logic              bank_we;
    logic [SLOT_W-1:0] bank_idx;
    logic [WORD_W-1:0] bank_val;
  } srt_upd_t;

  typedef struct packed {
    logic              reg_write;
    logic [3:0]        reg_index;
    logic [WORD_W-1:0] reg_value;
    logic [WORD_W-1:0] status_now;
    logic              unpredictable;
  } srt_res_t;

  function automatic srt_slot_t mode_slot(input logic [4:0] mode);
    srt_slot_t s;
    s.valid = 1'b1;
    s.idx   = SLOT_FIQ;
    case (mode)
      MODE_FIQ: s.idx = SLOT_FIQ;
      MODE_IRQ: s.idx = SLOT_IRQ;
      MODE_SVC: s.idx = SLOT_SVC;
      MODE_ABT: s.idx = SLOT_ABT;
      MODE_UND: s.idx = SLOT_UND;
      default:  s.valid = 1'b0;
    endcase
    return s;
  endfunction

  // Zero-extended 8-bit immediate rotated right by twice the rotate field
  function automatic logic [WORD_W-1:0] rot_imm(input logic [7:0] imm,
                                                input logic [3:0] rot);
    logic [2*WORD_W-1:0] dbl;
    logic [4:0]          amt;
    dbl = {{(WORD_W-8){1'b0}}, imm, {(WORD_W-8){1'b0}}, imm};
    amt = {rot, 1'b0};
    return dbl[amt +: WORD_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/status_register_transfer_top.sv
// Top level of the status register transfer unit: input stage, execute, result stage.
//
// Executes read-status-to-register and write-to-status instructions against a
// current status word and five banked saved words (fiq, irq, svc, abt, und).
// Throughput is one instruction per clock while the output is drained. An accepted
// transaction is held in the input register and executed there, and its result is
// loaded into the output register once that is empty or being drained. The input
// stalls only while both registers hold a transaction and the output is not drained.
// The status words are updated at the same edge that loads the result, so the next
// instruction already sees them. Reset sets the current word to 0x000001D3 and clears
// the saved words.
`default_nettype none

module status_register_transfer_top
  import srt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] instruction, [63:32] reg_operand
  input  wire logic [0:0]  in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [3:0] reg_index, [35:4] reg_value,
                                       // [67:36] status_now, [71:68] zero
  output logic [1:0]       out_tuser   // [0] reg_write, [1] unpredictable
);

  logic              in_valid_r;
  logic              func_r;
  logic [WORD_W-1:0] instr_r;
  logic [WORD_W-1:0] regop_r;
  logic              out_valid_r;
  srt_res_t          res_r;

  logic              out_free;
  logic              exec_fire;
  logic [WORD_W-1:0] cur_status;
  srt_slot_t         slot;
  logic [WORD_W-1:0] saved_status;
  srt_upd_t          upd;
  srt_res_t          res_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign exec_fire = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r  <= in_tuser[0];
      instr_r <= in_tdata[31:0];
      regop_r <= in_tdata[63:32];
    end
  end

  srt_state u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd_en       (exec_fire),
    .upd          (upd),
    .cur_status   (cur_status),
    .slot         (slot),
    .saved_status (saved_status)
  );

  srt_exec u_exec (
    .func         (func_r),
    .instruction  (instr_r),
    .reg_operand  (regop_r),
    .cur_status   (cur_status),
    .slot         (slot),
    .saved_status (saved_status),
    .upd          (upd),
    .res          (res_nxt)
  );

  // advance the result register whenever it is empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.status_now, res_r.reg_value, res_r.reg_index};
  assign out_tuser  = {res_r.unpredictable, res_r.reg_write};

endmodule

`default_nettype wire

FILE: rtl/core/srt_state.sv
// Current status word and banked saved status words.
`default_nettype none

module srt_state
  import srt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              upd_en,
  input  wire srt_upd_t          upd,
  output logic      [WORD_W-1:0] cur_status,
  output srt_slot_t              slot,
  output logic      [WORD_W-1:0] saved_status
);

  logic [WORD_W-1:0] cur_r;
  logic [WORD_W-1:0] bank_r [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= RESET_STATUS;
      for (int i = 0; i < BANK_DEPTH; i++) begin
        bank_r[i] <= '0;
      end
    end else if (upd_en) begin
      if (upd.cur_we) begin
        cur_r <= upd.cur_val;
      end
      if (upd.bank_we) begin
        bank_r[upd.bank_idx] <= upd.bank_val;
      end
    end
  end

  assign cur_status   = cur_r;
  assign slot         = mode_slot(cur_r[4:0]);
  assign saved_status = slot.valid ? bank_r[slot.idx] : '0;

endmodule

`default_nettype wire

FILE: rtl/core/srt_exec.sv
// Execute logic for one read-status or write-status instruction.
`default_nettype none

module srt_exec
  import srt_pkg::*;
(
  input  wire logic              func,
  input  wire logic [WORD_W-1:0] instruction,
  input  wire logic [WORD_W-1:0] reg_operand,
  input  wire logic [WORD_W-1:0] cur_status,
  input  wire srt_slot_t         slot,
  input  wire logic [WORD_W-1:0] saved_status,
  output srt_upd_t               upd,
  output srt_res_t               res
);

  logic              use_saved;
  logic              use_imm;
  logic [WORD_W-1:0] operand;
  logic [WORD_W-1:0] fields;
  logic [WORD_W-1:0] mask;
  logic              unpred;

  assign use_saved = instruction[22];
  assign use_imm   = instruction[25];
  assign operand   = use_imm ? rot_imm(instruction[7:0], instruction[11:8]) : reg_operand;

  always_comb begin
    fields = '0;
    if (instruction[16]) fields = fields | FIELD_C;
    if (instruction[17]) fields = fields | FIELD_X;
    if (instruction[18]) fields = fields | FIELD_S;
    if (instruction[19]) fields = fields | FIELD_F;
  end

  always_comb begin
    upd      = '0;
    upd.bank_idx = slot.idx;
    res      = '0;
    mask     = '0;
    unpred   = 1'b0;
    if (func == FUNC_READ) begin
      res.reg_write = 1'b1;
      res.reg_index = instruction[15:12];
      if (instruction[15:12] == REG_PC) unpred = 1'b1;
      if (use_saved) begin
        res.reg_value = saved_status;
        if (!slot.valid) unpred = 1'b1;
      end else begin
        res.reg_value = cur_status;
      end
    end else begin
      if ((operand & UNALLOC_BITS) != '0) unpred = 1'b1;
      if (use_saved) begin
        if (slot.valid) begin
          mask         = fields & (FLAG_BITS | CTRL_BITS | STATE_BIT);
          upd.bank_we  = 1'b1;
          upd.bank_val = (saved_status & ~mask) | (operand & mask);
        end else begin
          unpred = 1'b1;
        end
      end else begin
        if (cur_status[4:0] != MODE_USR) begin
          // privileged: control bits too, but never the state bit
          if ((operand & STATE_BIT) == '0) begin
            mask = fields & (FLAG_BITS | CTRL_BITS);
          end else begin
            unpred = 1'b1;
          end
        end else begin
          mask = fields & FLAG_BITS;
        end
        upd.cur_we  = 1'b1;
        upd.cur_val = (cur_status & ~mask) | (operand & mask);
      end
    end
    res.status_now    = upd.cur_we ? upd.cur_val : cur_status;
    res.unpredictable = unpred;
  end

endmodule

`default_nettype wire

FILE: verif/status_register_transfer_top_tb.sv
// Self-checking testbench for the status register transfer unit.
`timescale 1ns / 100ps

module status_register_transfer_top_tb
  import srt_pkg::*;
();

  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [3:0]  FM_NONE = 4'b0000;
  localparam logic [3:0]  FM_C    = 4'b0001;
  localparam logic [3:0]  FM_X    = 4'b0010;
  localparam logic [3:0]  FM_S    = 4'b0100;
  localparam logic [3:0]  FM_F    = 4'b1000;
  localparam logic [3:0]  FM_ALL  = 4'b1111;
  localparam logic [4:0]  MODE_SYS = 5'h1F;
  localparam logic [4:0]  MODE_BAD = 5'h05;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  // Shadow of the status words
  logic [31:0] cur_status;
  logic [31:0] saved_bank [BANK_DEPTH];

  srt_res_t    xfer_results_q [$];
  int          errors;
  int          stall_cycles;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int          rx_hold_left;

  status_register_transfer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int bank_index(input logic [4:0] mode);
    case (mode)
      MODE_FIQ: return int'(SLOT_FIQ);
      MODE_IRQ: return int'(SLOT_IRQ);
      MODE_SVC: return int'(SLOT_SVC);
      MODE_ABT: return int'(SLOT_ABT);
      MODE_UND: return int'(SLOT_UND);
      default:  return -1;
    endcase
  endfunction

  function automatic logic [31:0] xfer_operand(input logic [31:0] ins, input logic [31:0] op);
    logic [31:0] v;
    int          n;
    if (!ins[25]) return op;
    v = {24'b0, ins[7:0]};
    n = 2 * int'(ins[11:8]);
    if (n == 0) return v;
    return (v >> n) | (v << (32 - n));
  endfunction

  // Execute one instruction on the shadow state and return its result
  function automatic srt_res_t exec_xfer(input logic f, input logic [31:0] ins,
                                         input logic [31:0] op);
    srt_res_t    r;
    logic [31:0] operand;
    logic [31:0] fields;
    logic [31:0] mask;
    int          slot;
    slot = bank_index(cur_status[4:0]);
    r = '0;
    if (f == FUNC_READ) begin
      r.reg_write = 1'b1;
      r.reg_index = ins[15:12];
      if (ins[15:12] == REG_PC) r.unpredictable = 1'b1;
      if (ins[22]) begin
        if (slot >= 0) r.reg_value = saved_bank[slot];
        else r.unpredictable = 1'b1;
      end else begin
        r.reg_value = cur_status;
      end
    end else begin
      operand = xfer_operand(ins, op);
      if ((operand & UNALLOC_BITS) != '0) r.unpredictable = 1'b1;
      fields = ({32{ins[16]}} & FIELD_C) | ({32{ins[17]}} & FIELD_X) |
               ({32{ins[18]}} & FIELD_S) | ({32{ins[19]}} & FIELD_F);
      mask = '0;
      if (ins[22]) begin
        if (slot >= 0) begin
          mask = fields & (FLAG_BITS | CTRL_BITS | STATE_BIT);
          saved_bank[slot] = (saved_bank[slot] & ~mask) | (operand & mask);
        end else begin
          r.unpredictable = 1'b1;
        end
      end else begin
        if (cur_status[4:0] != MODE_USR) begin
          if ((operand & STATE_BIT) == '0) mask = fields & (FLAG_BITS | CTRL_BITS);
          else r.unpredictable = 1'b1;
        end else begin
          mask = fields & FLAG_BITS;
        end
        cur_status = (cur_status & ~mask) | (operand & mask);
      end
    end
    r.status_now = cur_status;
    return r;
  endfunction

  function automatic logic [31:0] mk_ins(input bit saved, input bit imm, input logic [3:0] fm,
                                         input logic [3:0] rd, input logic [3:0] rot,
                                         input logic [7:0] imm8);
    logic [31:0] w;
    w = '0;
    w[25]    = imm;
    w[22]    = saved;
    w[19:16] = fm;
    w[15:12] = rd;
    w[11:8]  = rot;
    w[7:0]   = imm8;
    return w;
  endfunction

  // Drive one transaction and record its expected result once accepted
  task automatic send_instr(input logic f, input logic [31:0] ins, input logic [31:0] op);
    int gap;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = f;
    in_tdata  = {op, ins};
    do @(posedge clk); while (!in_tready);
    xfer_results_q.push_back(exec_xfer(f, ins, op));
  endtask

  task automatic gen_item(input bit allow_user, output logic f, output logic [31:0] ins,
                          output logic [31:0] op);
    logic [31:0] operand;
    do begin
      f   = 1'($urandom_range(0, 1));
      ins = $urandom;
      op  = $urandom;
      if ($urandom_range(0, 3) != 0) op[5] = 1'b0;
      if ($urandom_range(0, 1) != 0) op[26:8] = '0;
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0: op[4:0] = MODE_FIQ;
          1: op[4:0] = MODE_IRQ;
          2: op[4:0] = MODE_SVC;
          3: op[4:0] = MODE_ABT;
          4: op[4:0] = MODE_UND;
          default: op[4:0] = MODE_SYS;
        endcase
      end
      if (ins[25] && $urandom_range(0, 1) != 0) begin
        ins[11:8] = 4'd0;
        ins[7:0]  = op[7:0];
      end
      operand = xfer_operand(ins, op);
    end while (!allow_user && f == FUNC_WRITE && !ins[22] && ins[16] &&
               !operand[5] && operand[4:0] == MODE_USR);
  endtask

  task automatic send_random(input int count, input bit allow_user);
    logic        f;
    logic [31:0] ins;
    logic [31:0] op;
    repeat (count) begin
      gen_item(allow_user, f, ins, op);
      send_instr(f, ins, op);
    end
  endtask

  // Drop the offer, then wait until every expected result has come
  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (xfer_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_reads();
    send_instr(FUNC_READ, mk_ins(1'b0, 1'b0, FM_NONE, 4'd0, 4'd0, 8'h00), 32'h0);
    send_instr(FUNC_READ, mk_ins(1'b1, 1'b0, FM_NONE, 4'd1, 4'd0, 8'h00), 32'hFFFF_FFFF);
    send_instr(FUNC_READ, 32'hFFFF_FFFF, 32'h0);
    send_instr(FUNC_READ, mk_ins(1'b0, 1'b0, FM_NONE, REG_PC, 4'd0, 8'h00), 32'h0);
  endtask

  task automatic test_field_writes();
    send_instr(FUNC_WRITE, 32'h0, 32'hFFFF_FFFF);
    send_instr(FUNC_WRITE, mk_ins(1'b1, 1'b0, FM_ALL, 4'd0, 4'd0, 8'h00), 32'hFFFF_FFFF);
    send_instr(FUNC_READ, mk_ins(1'b1, 1'b0, FM_NONE, 4'd2, 4'd0, 8'h00), 32'h0);
    send_instr(FUNC_WRITE, mk_ins(1'b0, 1'b1, FM_F, 4'd0, 4'd4, 8'hF0), 32'h0);
    // State bit in a privileged operand blocks the whole write
    send_instr(FUNC_WRITE, mk_ins(1'b0, 1'b0, FM_C, 4'd0, 4'd0, 8'h00), 32'h0000_0033);
    send_instr(FUNC_WRITE, mk_ins(1'b0, 1'b1, FM_C, 4'd0, 4'd0, 8'hFF), 32'h0);
    send_instr(FUNC_WRITE, mk_ins(1'b0, 1'b0, FM_X | FM_S, 4'd0, 4'd0, 8'h00),
               32'h00FF_FF00);
    send_instr(FUNC_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_mode_banks();
    logic [4:0] modes [5];
    modes = '{MODE_FIQ, MODE_UND, MODE_SYS, MODE_BAD, MODE_SVC};
    foreach (modes[i]) begin
      send_instr(FUNC_WRITE, mk_ins(1'b0, 1'b0, FM_C, 4'd0, 4'd0, 8'h00), {27'h6, modes[i]});
      send_instr(FUNC_WRITE, mk_ins(1'b1, 1'b0, FM_ALL, 4'd0, 4'd0, 8'h00),
                 $urandom & ~UNALLOC_BITS);
      send_instr(FUNC_READ, mk_ins(1'b1, 1'b0, FM_NONE, 4'd3, 4'd0, 8'h00), 32'h0);
    end
  endtask

  task automatic test_output_backpressure();
    rx_hold_left = 80;
    send_random(40, 1'b0);
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      send_random(12, 1'b0);
      wait_results_drained();
    end
  endtask

  // User mode cannot be left, so it comes last
  task automatic test_user_mode();
    send_instr(FUNC_WRITE, mk_ins(1'b0, 1'b0, FM_C, 4'd0, 4'd0, 8'h00), {27'h0, MODE_USR});
    send_instr(FUNC_READ, mk_ins(1'b1, 1'b0, FM_NONE, 4'd4, 4'd0, 8'h00), 32'h0);
    send_instr(FUNC_WRITE, mk_ins(1'b1, 1'b0, FM_ALL, 4'd0, 4'd0, 8'h00), 32'h0);
    send_instr(FUNC_WRITE, mk_ins(1'b0, 1'b0, FM_ALL, 4'd0, 4'd0, 8'h00), 32'hFFFF_FFFF);
    send_instr(FUNC_WRITE, mk_ins(1'b0, 1'b0, FM_ALL, 4'd0, 4'd0, 8'h00), 32'h0000_00D3);
    send_random(200, 1'b1);
  endtask

  // Receiver: random ready bursts plus a long hold on request
  initial begin
    int gap_left;
    gap_left   = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_tready = 1'b0;
        rx_hold_left--;
      end else if (rx_idle_en && gap_left > 0) begin
        out_tready = 1'b0;
        gap_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        gap_left   = $urandom_range(1, 13) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    srt_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (xfer_results_q.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction pending, actual %h %h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = xfer_results_q.pop_front();
        check_field("reg_write", 32'(want.reg_write), 32'(out_tuser[0]));
        check_field("reg_index", 32'(want.reg_index), 32'(out_tdata[3:0]));
        check_field("reg_value", want.reg_value, out_tdata[35:4]);
        check_field("status_now", want.status_now, out_tdata[67:36]);
        check_field("unpredictable", 32'(want.unpredictable), 32'(out_tuser[1]));
      end
    end
  end

  // Watchdog: cycles in a row with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("status_register_transfer_top verification failed");
      $finish;
    end
  end

  initial begin
    errors       = 0;
    stall_cycles = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    rx_hold_left = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cur_status   = RESET_STATUS;
    foreach (saved_bank[i]) saved_bank[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_reads();
    test_field_writes();
    test_mode_banks();
    send_random(600, 1'b0);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(300, 1'b0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_output_backpressure();
    test_drain_pause();
    send_random(350, 1'b0);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_user_mode();

    @(negedge clk);
    in_tvalid = 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status_register_transfer_top verification clean");
    end else begin
      $display("status_register_transfer_top verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/srt_pkg.sv
rtl/core/srt_state.sv
rtl/core/srt_exec.sv
rtl/core/status_register_transfer_top.sv
verif/status_register_transfer_top_tb.sv
